// ----- rtl/core/tga_rle_pixel_decoder_top_assert.svh -----
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_top_assert.svh
// Assertion macros for the TGA RLE pixel decoder. Expect clk and rst_n in
// the scope of use.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define TGARLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tga rle decoder: same-cycle property failed");

// next-cycle implication
`define TGARLE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tga rle decoder: next-cycle property failed");

`endif

// ----- rtl/core/tgarle_pkg.sv -----
// ---------------------------------------------------------------------------
// tgarle_pkg
// Types, register indexes and pixel helpers for the TGA RLE pixel decoder.
// ---------------------------------------------------------------------------
package tgarle_pkg;

  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_RLE_MODE        = 2'd1;
  localparam logic [1:0] CFG_IMAGE_PIXELS    = 2'd2;

  localparam logic [2:0]  BPP_RESET    = 3'd3;
  localparam logic        RLE_RESET    = 1'b1;
  localparam logic [31:0] PIXELS_RESET = 32'd1;

  localparam logic [7:0] MAX_REPEAT = 8'd128;

  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        rle_mode;
    logic [31:0] image_pixels;
  } cfg_t;

  typedef struct packed {
    logic        expect_header;
    logic        run_packet;
    logic [7:0]  packet_left;
    logic [1:0]  byte_index;
    logic [31:0] pixel_assembly;
    logic [31:0] pixels_left;
    logic        stopped;
    logic        clip_flag;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overrun;
  } result_t;

  function automatic logic [2:0] pixel_size(input logic [2:0] bpp);
    logic [2:0] s;
    if (bpp < 3'd2) begin
      s = 3'd2;
    end else if (bpp > 3'd4) begin
      s = 3'd4;
    end else begin
      s = bpp;
    end
    return s;
  endfunction

  function automatic logic [31:0] colour_swap(input logic [31:0] a, input logic [2:0] size);
    logic [31:0] r;
    case (size)
      3'd2:    r = {16'd0, a[4:0], a[10:5], a[15:11]};
      3'd3:    r = {8'd0, a[7:0], a[15:8], a[23:16]};
      default: r = {a[31:24], a[7:0], a[15:8], a[23:16]};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/tgarle_step.sv -----
// ---------------------------------------------------------------------------
// tgarle_step
// Decode step for one payload byte: header parsing, pixel assembly, colour
// swap, repeat clipping and image pixel count.
// ---------------------------------------------------------------------------
module tgarle_step (
  input  tgarle_pkg::cfg_t       cfg,
  input  tgarle_pkg::dec_state_t st,
  input  logic [7:0]             data_byte,
  input  logic                   frame_start,
  output tgarle_pkg::dec_state_t st_nxt,
  output tgarle_pkg::result_t    res
);

  tgarle_pkg::dec_state_t cur;
  logic [2:0]  size;
  logic [31:0] asm_new;
  logic [7:0]  cnt;
  logic [7:0]  rep;
  logic [7:0]  pkt_rem;
  logic [31:0] px_rem;
  logic [2:0]  bi_inc;

  always_comb begin
    cur = st;
    if (frame_start) begin
      cur.expect_header  = 1'b1;
      cur.run_packet     = 1'b0;
      cur.packet_left    = 8'd0;
      cur.byte_index     = 2'd0;
      cur.pixel_assembly = 32'd0;
      cur.clip_flag      = 1'b0;
      cur.pixels_left    = cfg.image_pixels;
      cur.stopped        = (cfg.image_pixels == 32'd0);
    end

    size    = tgarle_pkg::pixel_size(cfg.bytes_per_pixel);
    asm_new = cur.pixel_assembly | ({24'd0, data_byte} << {cur.byte_index, 3'b000});
    bi_inc  = {1'b0, cur.byte_index} + 3'd1;
    cnt     = {1'b0, data_byte[6:0]} + 8'd1;
    rep     = (cfg.rle_mode && cur.run_packet) ? cur.packet_left : 8'd1;
    if ({24'd0, rep} > cur.pixels_left) begin
      rep = cur.pixels_left[7:0];
    end
    pkt_rem = cur.packet_left - rep;
    px_rem  = cur.pixels_left - {24'd0, rep};

    st_nxt           = cur;
    res.valid        = 1'b0;
    res.pixel_value  = tgarle_pkg::colour_swap(asm_new, size);
    res.repeat_count = rep;
    res.image_done   = (px_rem == 32'd0);
    res.overrun      = 1'b0;

    if (cur.stopped || (cur.pixels_left == 32'd0)) begin
      st_nxt = cur;
    end else if (cfg.rle_mode && (cur.expect_header || (cur.packet_left == 8'd0))) begin
      st_nxt.clip_flag = 1'b0;
      st_nxt.packet_left = cnt;
      if ({24'd0, cnt} > cur.pixels_left) begin
        st_nxt.packet_left = cur.pixels_left[7:0];
        st_nxt.clip_flag   = 1'b1;
      end
      st_nxt.run_packet     = data_byte[7];
      st_nxt.expect_header  = 1'b0;
      st_nxt.byte_index     = 2'd0;
      st_nxt.pixel_assembly = 32'd0;
    end else if (bi_inc < size) begin
      st_nxt.pixel_assembly = asm_new;
      st_nxt.byte_index     = bi_inc[1:0];
    end else begin
      res.valid             = 1'b1;
      st_nxt.byte_index     = 2'd0;
      st_nxt.pixel_assembly = 32'd0;
      if (cfg.rle_mode) begin
        st_nxt.packet_left = pkt_rem;
        if (pkt_rem == 8'd0) begin
          res.overrun          = cur.clip_flag;
          st_nxt.clip_flag     = 1'b0;
          st_nxt.expect_header = 1'b1;
        end
      end
      st_nxt.pixels_left = px_rem;
      if (px_rem == 32'd0) begin
        st_nxt.stopped = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tga_rle_pixel_decoder_top.sv -----
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA payload decoder: bytes in, colour-swapped pixels with repeat counts out.
// ---------------------------------------------------------------------------
// Takes one payload byte per cycle and gives at most one pixel per byte.
// A byte lands in an input register and is decoded in one pass (header,
// assembly, swap, clipping, pixel count) into the result register, so a
// pixel passes the input register and the result register on its way out.
// Throughput is one byte per cycle, set by the single decode pass;
// only a stall on the result side holds bytes back. Configuration writes are
// always ready and must be made while no byte is in flight; image_pixels
// is loaded by a byte flagged with frame_start.
module tga_rle_pixel_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic        out_image_done,
  output logic        out_overrun,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tgarle_pkg::cfg_t       cfg_r;
  tgarle_pkg::dec_state_t st_r;
  tgarle_pkg::dec_state_t st_nxt;
  tgarle_pkg::result_t    res;

  logic        in_full_r;
  logic [7:0]  in_data_r;
  logic        in_fs_r;
  logic        in_take;
  logic        adv;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] pix_r;
  logic [7:0]  rep_r;
  logic        done_r;
  logic        ovr_r;

  assign cfg_ready = 1'b1;
  assign adv       = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_full_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid_nxt = adv ? res.valid : (out_valid_r && out_stall);

  tgarle_step u_step (
    .cfg         (cfg_r),
    .st          (st_r),
    .data_byte   (in_data_r),
    .frame_start (in_fs_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_pixel <= tgarle_pkg::BPP_RESET;
      cfg_r.rle_mode        <= tgarle_pkg::RLE_RESET;
      cfg_r.image_pixels    <= tgarle_pkg::PIXELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgarle_pkg::CFG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::CFG_RLE_MODE:        cfg_r.rle_mode        <= cfg_data[0];
        tgarle_pkg::CFG_IMAGE_PIXELS:    cfg_r.image_pixels    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.expect_header  <= 1'b1;
      st_r.run_packet     <= 1'b0;
      st_r.packet_left    <= 8'd0;
      st_r.byte_index     <= 2'd0;
      st_r.pixel_assembly <= 32'd0;
      st_r.pixels_left    <= 32'd0;
      st_r.stopped        <= 1'b0;
      st_r.clip_flag      <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_take || (in_full_r && !adv);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data_byte;
      in_fs_r   <= in_frame_start;
    end
    if (adv && res.valid) begin
      pix_r  <= res.pixel_value;
      rep_r  <= res.repeat_count;
      done_r <= res.image_done;
      ovr_r  <= res.overrun;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = pix_r;
  assign out_repeat_count = rep_r;
  assign out_image_done   = done_r;
  assign out_overrun      = ovr_r;

`include "tga_rle_pixel_decoder_top_assert.svh"

  `TGARLE_ASSERT_IMP(a_rep_range, out_valid_r, (rep_r != 8'd0) && (rep_r <= tgarle_pkg::MAX_REPEAT))
  `TGARLE_ASSERT_IMP(a_ovr_done, out_valid_r && ovr_r, done_r)
  `TGARLE_ASSERT_NXT(a_done_stops, adv && res.valid && res.image_done, st_r.stopped)
  `TGARLE_ASSERT_IMP(a_pkt_bound, 1'b1, st_r.packet_left <= tgarle_pkg::MAX_REPEAT)

endmodule

// ----- dv/tga_rle_pixel_decoder_checker.sv -----
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_checker
// Watches the byte, pixel and register channels of the TGA pixel decoder,
// predicts every decoded pixel and compares the pixels that leave the block.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_pixel_value,
  input  logic [7:0]  out_repeat_count,
  input  logic        out_image_done,
  input  logic        out_overrun,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          expected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  rep_count;
    logic        done;
    logic        ovr;
  } pixel_item_t;

  logic [2:0]  cfg_bpp;
  logic        cfg_rle;
  logic [31:0] cfg_pixels;

  logic        want_header;
  logic        in_run;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [31:0] acc;
  logic [31:0] px_left;
  logic        halted;
  logic        clipped;

  pixel_item_t pixel_q[$];
  pixel_item_t got;
  pixel_item_t want;
  int          errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_packet();
    want_header = 1'b1;
    in_run      = 1'b0;
    pkt_left    = 8'd0;
    byte_pos    = 2'd0;
    acc         = 32'd0;
    clipped     = 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                     output pixel_item_t r);
    int          sz;
    logic [31:0] cnt;
    logic [31:0] rep;
    logic [31:0] v;
    logic [31:0] sw;
    r = '0;
    if (fs) begin
      clear_packet();
      px_left = cfg_pixels;
      halted  = (cfg_pixels == 32'd0);
    end
    if (halted || px_left == 32'd0) begin
      return 1'b0;
    end
    if (cfg_rle && (want_header || pkt_left == 8'd0)) begin
      cnt     = {25'd0, b[6:0]} + 32'd1;
      clipped = 1'b0;
      if (cnt > px_left) begin
        cnt     = px_left;
        clipped = 1'b1;
      end
      in_run      = b[7];
      pkt_left    = cnt[7:0];
      want_header = 1'b0;
      byte_pos    = 2'd0;
      acc         = 32'd0;
      return 1'b0;
    end
    sz  = (cfg_bpp < 3'd2) ? 2 : (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);
    acc = acc | ({24'd0, b} << (8 * byte_pos));
    if (int'(byte_pos) + 1 < sz) begin
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    // red/blue swap: 5-bit fields for 16-bit, bytes 0 and 2 otherwise
    if (sz == 2) begin
      v  = acc & 32'h0000_FFFF;
      sw = (v & 32'h0000_07E0) | (v >> 11) | ((v << 11) & 32'h0000_FFFF);
    end else begin
      v  = (sz == 3) ? (acc & 32'h00FF_FFFF) : acc;
      sw = (v & 32'hFF00_FF00) | ((v >> 16) & 32'h0000_00FF) | ((v & 32'h0000_00FF) << 16);
    end
    byte_pos = 2'd0;
    acc      = 32'd0;
    if (cfg_rle) begin
      rep = in_run ? {24'd0, pkt_left} : 32'd1;
      if (rep > px_left) begin
        rep = px_left;
      end
      pkt_left = pkt_left - rep[7:0];
      if (pkt_left == 8'd0) begin
        r.ovr       = clipped;
        clipped     = 1'b0;
        want_header = 1'b1;
      end
    end else begin
      rep = 32'd1;
    end
    px_left     = px_left - rep;
    r.done      = (px_left == 32'd0);
    halted      = halted | r.done;
    r.pixel     = sw;
    r.rep_count = rep[7:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_bpp    = tgarle_pkg::BPP_RESET;
      cfg_rle    = tgarle_pkg::RLE_RESET;
      cfg_pixels = tgarle_pkg::PIXELS_RESET;
      clear_packet();
      px_left    = 32'd0;
      halted     = 1'b0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tgarle_pkg::CFG_BYTES_PER_PIXEL: cfg_bpp    = cfg_data[2:0];
          tgarle_pkg::CFG_RLE_MODE:        cfg_rle    = cfg_data[0];
          tgarle_pkg::CFG_IMAGE_PIXELS:    cfg_pixels = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data_byte, in_frame_start, want)) begin
          pixel_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_pixel_value, out_repeat_count, out_image_done, out_overrun};
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h", got.pixel));
        end else begin
          want = pixel_q.pop_front();
          if (got.pixel !== want.pixel) begin
            report_mismatch($sformatf("pixel_value %h, want %h", got.pixel, want.pixel));
          end
          if (got.rep_count !== want.rep_count) begin
            report_mismatch($sformatf("repeat_count %0d, want %0d",
                                      got.rep_count, want.rep_count));
          end
          if (got.done !== want.done) begin
            report_mismatch($sformatf("image_done %b, want %b", got.done, want.done));
          end
          if (got.ovr !== want.ovr) begin
            report_mismatch($sformatf("overrun %b, want %b", got.ovr, want.ovr));
          end
        end
      end
    end
    expected_count <= pixel_q.size();
    fail_count     <= errors;
  end

endmodule

// ----- dv/tga_rle_pixel_decoder_top_tb.sv -----
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_top_tb
// Drives TGA payload streams, raw and run-length coded, into the decoder at
// all pixel sizes and lets the checker compare every decoded pixel.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 560;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pixel_value;
  logic [7:0]  out_repeat_count;
  logic        out_image_done;
  logic        out_overrun;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  int          fail_count;
  int          expected_count;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          sent_count = 0;
  int          quiet_cycles = 0;
  int          img_bytes;
  bit          img_cut;

  logic [2:0]  cur_bpp = tgarle_pkg::BPP_RESET;
  logic        cur_rle = tgarle_pkg::RLE_RESET;
  logic [31:0] cur_pixels = tgarle_pkg::PIXELS_RESET;

  tga_rle_pixel_decoder_top dut (.*);

  tga_rle_pixel_decoder_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tga_rle_pixel_decoder_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
    sent_count -= n;
  endtask

  task automatic wait_for_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tgarle_pkg::CFG_BYTES_PER_PIXEL: cur_bpp    = d[2:0];
      tgarle_pkg::CFG_RLE_MODE:        cur_rle    = d[0];
      tgarle_pkg::CFG_IMAGE_PIXELS:    cur_pixels = d;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [2:0] bpp, input logic rle, input logic [31:0] pix);
    write_reg(tgarle_pkg::CFG_BYTES_PER_PIXEL, {29'($urandom), bpp});
    write_reg(tgarle_pkg::CFG_RLE_MODE, {31'($urandom), rle});
    write_reg(tgarle_pkg::CFG_IMAGE_PIXELS, pix);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [2:0]  bpp;
    logic [31:0] pix;
    bpp = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2, 4));
    case ($urandom_range(19))
      0, 1:    pix = 32'd0;
      2, 3:    pix = $urandom_range(25, 64);
      4, 5, 6: pix = $urandom;
      default: pix = $urandom_range(1, 24);
    endcase
    write_config(bpp, $urandom_range(4) != 0, pix);
  endtask

  task automatic image_byte(input logic [7:0] d, input int cut_at);
    if (img_cut) return;
    if (img_bytes == cut_at) begin
      img_cut = 1'b1;
      return;
    end
    send_byte(d, img_bytes == 0);
    img_bytes++;
  endtask

  // one image: frame start on its first byte, packets sized to the image,
  // now and then cut short
  task automatic send_image();
    int   sz;
    int   left;
    int   cnt;
    int   n;
    int   cut_at;
    logic run;
    sz        = (cur_bpp < 3'd2) ? 2 : (cur_bpp > 3'd4) ? 4 : int'(cur_bpp);
    left      = (cur_pixels > 32'd64) ? 64 : int'(cur_pixels);
    img_bytes = 0;
    img_cut   = 1'b0;
    cut_at    = ($urandom_range(9) == 0) ? int'($urandom_range(1, 4 * sz)) : -1;
    if (left == 0) begin
      repeat (3) image_byte(8'($urandom_range(255)), cut_at);
    end
    while (left > 0) begin
      if (cur_rle) begin
        run = $urandom_range(1);
        case ($urandom_range(9))
          0:       cnt = 127;
          1:       cnt = $urandom_range(127);
          default: cnt = $urandom_range(7);
        endcase
        n = (cnt + 1 < left) ? cnt + 1 : left;
        image_byte({run, cnt[6:0]}, cut_at);
        repeat ((run ? 1 : n) * sz) image_byte(8'($urandom_range(255)), cut_at);
        left -= n;
      end else begin
        repeat (sz) image_byte(8'($urandom_range(255)), cut_at);
        left--;
      end
    end
    if (img_cut && $urandom_range(1)) begin
      wait_for_pixels();
      random_config();
      repeat (12) send_byte(8'($urandom_range(255)), 1'b0);
    end else if ($urandom_range(3) == 0) begin
      send_noise($urandom_range(1, 4));
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent_count  = 0;
    while (sent_count < PHASE_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        wait_for_pixels();
        random_config();
      end
      send_image();
    end
    wait_for_pixels();
  endtask

  task automatic directed();
    // no frame started yet
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_for_pixels();
    // empty image
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(tgarle_pkg::CFG_IMAGE_PIXELS, 32'd0);
    cfg_valid <= 1'b0;
    send_byte(8'h81, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_for_pixels();
    // longest run, then a run clipped at the end of the image
    write_config(3'd3, 1'b1, 32'd130);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h85, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    wait_for_pixels();
    // raw 16-bit
    write_config(3'd2, 1'b0, 32'd2);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'hA0, 1'b0);
    wait_for_pixels();
    // literal packet of 32-bit pixels
    write_config(3'd4, 1'b1, 32'd2);
    send_byte(8'h01, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    wait_for_pixels();
  endtask

  // pixel side held off while bytes keep coming
  task automatic hold_off_test();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(3'd2, 1'b0, 32'd40);
    hold_req = 1'b1;
    send_byte(8'($urandom_range(255)), 1'b1);
    repeat (79) send_byte(8'($urandom_range(255)), 1'b0);
    wait_for_pixels();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    run_phase(19, 52);
    run_phase(52, 19);
    hold_off_test();
    run_phase(0, 0);
    if (fail_count == 0 && expected_count == 0) begin
      $display("tga_rle_pixel_decoder_top_tb: done, clean");
    end else begin
      $display("tga_rle_pixel_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
